/* rtl/assert_macros.svh */
// Assertion helpers for the RTL; included by msb_first_bit_buffer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clock, reset_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(label, clock, reset_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mfbb_pkg.sv */
`default_nettype none

package mfbb_pkg;

	// Default sizing
	localparam int BUF_BYTES_DEF      = 256;
	localparam int MAX_FIELD_BITS_DEF = 32;

	// Field widths
	localparam int REQ_W    = 4;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 6;
	localparam int SKIP_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int RESULT_W = 32;
	localparam int TOTAL_W  = 12;
	localparam int BCOUNT_W = 9;

	// Stream widths
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 64;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PACK     = 4'd0,
		REQ_UNPACK_U = 4'd1,
		REQ_UNPACK_S = 4'd2,
		REQ_PEEK     = 4'd3,
		REQ_SKIP     = 4'd4,
		REQ_REWIND   = 4'd5,
		REQ_CLEAR    = 4'd6,
		REQ_LOAD     = 4'd7,
		REQ_RDBYTE   = 4'd8
	} req_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_MOD   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

endpackage

`default_nettype wire

/* rtl/mfbb_ram.sv */
`default_nettype none

module mfbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/msb_first_bit_buffer.sv */
// Channel   Dir  Payload (lowest bit first)
// s_axis    in   tuser: req_type; tdata: field_value, bit_count, skip_bits, load_byte,
//                byte_index
// m_axis    out  tdata: result_value, stored_byte, total_bits, byte_count, overflow
//
// Pack, unpack and peek run one read step and one merge (pack) or extract step of the
// byte store per byte touched; a 32-bit field touches four or five bytes.
// A zero-width field goes from the fetch step straight to finishing. Past capacity, a read
// shifts in zeros a byte per fetch step, a pack drops its bits, and a check precedes finishing.
// Skip, rewind, load and unknown requests go straight to finishing; an in-range read byte fetches first.
// After reset, and after a clear request, a zeroing pass writes one byte a cycle over all
// BUF_BYTES bytes; no word is accepted during it.
// s_axis_tready is high only while idle; a finished result waits in the output register
// while m_axis_tready is low, and the next word may be worked on meanwhile.
`default_nettype none

`include "assert_macros.svh"

module msb_first_bit_buffer
	import mfbb_pkg::*;
#(
	parameter int BUF_BYTES      = BUF_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// field_value[31:0], bit_count[37:32], skip_bits[49:38], load_byte[57:50],
	// byte_index[65:58], zero pad [71:66]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type[3:0]
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// result_value[31:0], stored_byte[39:32], total_bits[51:40], byte_count[60:52],
	// overflow[61], zero pad [63:62]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int CAP_BITS = BUF_BYTES * 8;
	localparam int POS_W    = $clog2(CAP_BITS + 1);
	localparam int ADDR_W   = $clog2(BUF_BYTES);
	localparam int FW       = (MAX_FIELD_BITS > VALUE_W) ? MAX_FIELD_BITS : VALUE_W;
	localparam int SUM_W    = POS_W + SKIP_W;
	localparam int IDX_W    = ADDR_W + BYTE_W;
	localparam int LD_W     = POS_W + BYTE_W + 1;
	localparam int TE_W     = POS_W + TOTAL_W;
	localparam int BE_W     = POS_W + BCOUNT_W + 1;

	// Sequencer and architectural state
	state_t                st_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      total_q;
	logic [ADDR_W-1:0]     clr_q;
	logic                  out_valid_q;

	// Request being worked on
	logic [REQ_W-1:0]      req_q;
	logic [FW-1:0]         sh_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [COUNT_W-1:0]    n_q;
	logic [SKIP_W-1:0]     skip_q;
	logic [BYTE_W-1:0]     lb_q;
	logic [BYTE_W-1:0]     idx_q;
	logic [POS_W-1:0]      wp_q;
	logic [RESULT_W-1:0]   acc_q;
	logic [BYTE_W-1:0]     sb_q;
	logic                  ovf_q;
	logic [OUT_TDATA_W-1:0] out_q;

	// Input word fields
	logic [REQ_W-1:0]      in_req;
	logic [VALUE_W-1:0]    in_val;
	logic [COUNT_W-1:0]    in_cnt;
	logic [COUNT_W:0]      in_sat;
	logic [COUNT_W-1:0]    in_n;
	logic [BYTE_W-1:0]     in_idx;
	logic                  in_idx_ok;
	logic                  accept;

	// Byte store port
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [BYTE_W-1:0]     ram_wdata;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [BYTE_W-1:0]     ram_rdata;

	// Chunk unit
	logic                  is_pack;
	logic                  is_rdbyte;
	logic                  past_cap;
	logic [ADDR_W-1:0]     wp_addr;
	logic [IDX_W-1:0]      idx_ext;
	logic [ADDR_W-1:0]     idx_addr;
	logic                  idx_ok;
	logic [2:0]            off;
	logic [3:0]            avail;
	logic [3:0]            k;
	logic [3:0]            k8;
	logic [BYTE_W-1:0]     lo_mask;
	logic [BYTE_W-1:0]     chunk_mask;
	logic [BYTE_W-1:0]     pack_byte;
	logic [BYTE_W-1:0]     rd_bits;
	logic [POS_W:0]        tsum;
	logic [POS_W-1:0]      total_add;

	// Finishing step
	logic                  slot_free;
	logic                  fin_fire;
	logic [SUM_W-1:0]      ssum;
	logic                  skip_ovf;
	logic [LD_W-1:0]       ld_total;
	logic [POS_W-1:0]      pos_nx;
	logic [POS_W-1:0]      total_nx;
	logic                  ovf_nx;
	logic [RESULT_W-1:0]   res_nx;
	logic [BYTE_W-1:0]     sb_nx;
	logic [4:0]            sign_idx;
	logic                  sign_ext;
	logic [TE_W-1:0]       tot_ext;
	logic [POS_W:0]        bc_raw;
	logic [BE_W-1:0]       bc_ext;

	mfbb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Unpack the input word
	assign in_req    = s_axis_tuser[REQ_W-1:0];
	assign in_val    = s_axis_tdata[31:0];
	assign in_cnt    = s_axis_tdata[37:32];
	assign in_idx    = s_axis_tdata[65:58];
	assign in_sat    = ({1'b0, in_cnt} > (COUNT_W+1)'(MAX_FIELD_BITS)) ?
		(COUNT_W+1)'(MAX_FIELD_BITS) : {1'b0, in_cnt};
	assign in_n      = in_sat[COUNT_W-1:0];
	assign in_idx_ok = ({24'd0, in_idx} < 32'(BUF_BYTES));

	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Decode the held request
	assign is_pack   = (req_q == REQ_PACK);
	assign is_rdbyte = (req_q == REQ_RDBYTE);
	assign past_cap  = (wp_q >= POS_W'(CAP_BITS));
	assign wp_addr   = wp_q[ADDR_W+2:3];
	assign idx_ext   = IDX_W'(idx_q);
	assign idx_addr  = idx_ext[ADDR_W-1:0];
	assign idx_ok    = ({24'd0, idx_q} < 32'(BUF_BYTES));

	// Slice of the current byte that this step covers
	assign off        = wp_q[2:0];
	assign avail      = 4'd8 - {1'b0, off};
	assign k          = (rem_q < {2'b00, avail}) ? rem_q[3:0] : avail;
	assign k8         = (rem_q < COUNT_W'(8)) ? rem_q[3:0] : 4'd8;
	assign lo_mask    = 8'hFF >> off;
	assign chunk_mask = lo_mask & ~(8'hFF >> ({1'b0, off} + k));
	assign pack_byte  = ram_rdata | ((sh_q[FW-1 -: BYTE_W] >> off) & chunk_mask);
	assign rd_bits    = (ram_rdata & lo_mask) >> (avail - k);
	assign tsum       = (POS_W+1)'(total_q) + (POS_W+1)'(k);
	assign total_add  = (tsum > (POS_W+1)'(CAP_BITS)) ? POS_W'(CAP_BITS) : tsum[POS_W-1:0];

	// Byte store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_addr;
		ram_wdata = pack_byte;
		ram_raddr = is_rdbyte ? idx_addr : wp_addr;
		unique case (st_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_MOD: begin
				ram_we = is_pack;
			end
			ST_FIN: begin
				ram_we    = fin_fire && (req_q == REQ_LOAD) && idx_ok;
				ram_waddr = idx_addr;
				ram_wdata = lb_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Finish: work out cursor, count and result of the request
	assign slot_free = !out_valid_q || m_axis_tready;
	assign fin_fire  = (st_q == ST_FIN) && slot_free;
	assign ssum      = SUM_W'(pos_q) + SUM_W'(skip_q);
	assign skip_ovf  = (ssum > SUM_W'(CAP_BITS));
	assign ld_total  = (LD_W'(idx_q) + LD_W'(1)) << 3;
	assign sign_idx  = n_q[4:0] - 5'd1;
	assign sign_ext  = (req_q == REQ_UNPACK_S) && (n_q != '0) && (n_q < COUNT_W'(32)) &&
		acc_q[sign_idx];

	always_comb begin
		pos_nx   = pos_q;
		total_nx = total_q;
		ovf_nx   = ovf_q;
		res_nx   = '0;
		sb_nx    = '0;
		unique case (req_q)
			REQ_PACK: begin
				pos_nx = wp_q;
			end
			REQ_UNPACK_U: begin
				pos_nx = wp_q;
				res_nx = acc_q;
			end
			REQ_UNPACK_S: begin
				pos_nx = wp_q;
				res_nx = sign_ext ? (acc_q | (32'hFFFF_FFFF << n_q[4:0])) : acc_q;
			end
			REQ_PEEK: begin
				res_nx = acc_q;
			end
			REQ_SKIP: begin
				pos_nx = skip_ovf ? POS_W'(CAP_BITS) : ssum[POS_W-1:0];
				ovf_nx = skip_ovf;
			end
			REQ_REWIND: begin
				pos_nx = '0;
			end
			REQ_CLEAR: begin
				pos_nx   = '0;
				total_nx = '0;
			end
			REQ_LOAD: begin
				if (idx_ok) begin
					pos_nx   = '0;
					total_nx = ld_total[POS_W-1:0];
				end else begin
					ovf_nx = 1'b1;
				end
			end
			REQ_RDBYTE: begin
				sb_nx  = sb_q;
				ovf_nx = !idx_ok;
			end
			default: begin
				ovf_nx = 1'b0;
			end
		endcase
	end

	assign tot_ext = TE_W'(total_nx);
	assign bc_raw  = ((POS_W+1)'(total_nx) + (POS_W+1)'(7)) >> 3;
	assign bc_ext  = BE_W'(bc_raw);

	// Sequencer, cursor, bit count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			pos_q       <= '0;
			total_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(BUF_BYTES - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_req == REQ_PACK || in_req == REQ_UNPACK_U ||
							in_req == REQ_UNPACK_S || in_req == REQ_PEEK ||
							(in_req == REQ_RDBYTE && in_idx_ok)) begin
							st_q <= ST_FETCH;
						end else begin
							st_q <= ST_FIN;
						end
					end
				end
				ST_FETCH: begin
					if (is_rdbyte) begin
						st_q <= ST_MOD;
					end else if (rem_q == '0) begin
						st_q <= ST_FIN;
					end else if (!past_cap) begin
						st_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (is_rdbyte || rem_q == COUNT_W'(k)) begin
						st_q <= ST_FIN;
					end else begin
						st_q <= ST_FETCH;
					end
					if (is_pack) begin
						total_q <= total_add;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						pos_q   <= pos_nx;
						total_q <= total_nx;
						if (req_q == REQ_CLEAR) begin
							clr_q <= '0;
							st_q  <= ST_CLEAR;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request registers and the shared chunk unit
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= in_req;
			sh_q   <= FW'(in_val) << (7'(FW) - {1'b0, in_n});
			rem_q  <= in_n;
			n_q    <= in_n;
			skip_q <= s_axis_tdata[49:38];
			lb_q   <= s_axis_tdata[57:50];
			idx_q  <= in_idx;
			wp_q   <= pos_q;
			acc_q  <= '0;
			sb_q   <= '0;
			ovf_q  <= 1'b0;
		end
		// Past capacity: drop packed bits, shift in zeros for reads
		if (st_q == ST_FETCH && !is_rdbyte && rem_q != '0 && past_cap) begin
			ovf_q <= 1'b1;
			if (is_pack) begin
				rem_q <= '0;
			end else begin
				rem_q <= rem_q - COUNT_W'(k8);
				acc_q <= acc_q << k8;
			end
		end
		// Merge or extract one slice of the fetched byte
		if (st_q == ST_MOD) begin
			if (is_rdbyte) begin
				sb_q <= ram_rdata;
			end else begin
				rem_q <= rem_q - COUNT_W'(k);
				wp_q  <= wp_q + POS_W'(k);
				sh_q  <= sh_q << k;
				acc_q <= (acc_q << k) | RESULT_W'(rd_bits);
			end
		end
		// Hold the finished word until taken
		if (fin_fire) begin
			out_q <= {2'b00, ovf_nx, bc_ext[BCOUNT_W-1:0], tot_ext[TOTAL_W-1:0], sb_nx,
				res_nx};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, accept, st_q != ST_IDLE,
		"accepted word did not start work")
	`ASSERT_NXT(a_fin_gives_word, clk, arst_n, fin_fire, m_axis_tvalid,
		"finished request gave no output word")
	`ASSERT_NXT(a_chunk_progress, clk, arst_n, (st_q == ST_MOD) && !is_rdbyte,
		rem_q < $past(rem_q), "chunk step made no progress")
	`ASSERT_NXT(a_clear_sweeps, clk, arst_n, fin_fire && (req_q == REQ_CLEAR),
		(st_q == ST_CLEAR) && (total_q == '0) && (pos_q == '0),
		"clear did not reset state and start the sweep")
	`ASSERT_IMP(a_within_cap, clk, arst_n, st_q == ST_IDLE,
		(pos_q <= POS_W'(CAP_BITS)) && (total_q <= POS_W'(CAP_BITS)),
		"cursor or bit count beyond capacity")

endmodule

`default_nettype wire
